FILE: hdl/header_tail_frame_sync_macros.svh
// Assertion macros shared by the frame synchroniser modules.
`ifndef HEADER_TAIL_FRAME_SYNC_MACROS_SVH
`define HEADER_TAIL_FRAME_SYNC_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define HTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hts assertion failed");
// Check that a condition never holds outside reset.
`define HTS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("hts forbidden condition seen");
`else
`define HTS_ASSERT(lbl, prop)
`define HTS_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: hdl/hts_pkg.sv
// Package: constants, types and control structs of the header/tail frame synchroniser.
package hts_pkg;

  localparam int unsigned FRAME_LEN = 20;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
  localparam int unsigned CNT_W     = $clog2(FRAME_LEN + 1);
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;
  localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'hFF;

  // Register index, taken from paddr[2].
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_TAIL   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic shift_in;   // store the accepted byte at the newest end
    logic rotate;     // move the oldest byte round to the newest end
    logic clr_count;  // restart the fill count
    logic clr_pos;    // restart the frame position
  } cmd_t;

  typedef struct packed {
    logic full;       // window holds FRAME_LEN bytes
    logic match;      // oldest equals header and newest equals tail
    logic pos_last;   // frame position is at the tail byte
  } status_t;

endpackage

FILE: hdl/header_tail_frame_sync.sv
// Top level: header/tail frame synchroniser with its APB register block.
//
// Usage:
//   Received bytes arrive on the rx channel (rx_valid_i, rx_stall_o, rx_byte_i);
//   a word is taken at a clock edge where rx_valid_i is high and rx_stall_o low.
//   The block keeps the last FRAME_LEN (20) bytes in a shift line. Once that
//   many bytes have come in since the last frame, it checks the oldest against
//   header_value and the newest against tail_value. On a match it sends the
//   window, oldest byte first, on the frame channel (frame_valid_o,
//   frame_stall_i), with byte_position_o counting from 0 and last_of_frame_o
//   high on the tail, then starts the fill count afresh.
//   Each byte is accepted, then compared with rx held off, before the next is taken;
//   on a match the window is shifted out, one word per cycle while the
//   receiver does not stall, and rx is held off meanwhile. A stalled word
//   stays unchanged on the outputs.
//   Reset clears the fill count and the state machine, leaves the window
//   contents as they are, and loads header 0x55 and tail 0xFF.
//   Registers: 0x0 header_value, 0x4 tail_value (low 8 bits);
//   write them only while the block is idle.

module header_tail_frame_sync (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // receive channel
  input  logic                             rx_valid_i,
  output logic                             rx_stall_o,
  input  logic [hts_pkg::BYTE_W-1:0]       rx_byte_i,
  // frame channel
  output logic                             frame_valid_o,
  input  logic                             frame_stall_i,
  output logic [hts_pkg::BYTE_W-1:0]       frame_byte_o,
  output logic [hts_pkg::POS_W-1:0]        byte_position_o,
  output logic                             last_of_frame_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hts_pkg::ADDR_W-1:0]       paddr,
  input  logic [hts_pkg::APB_DW-1:0]       pwdata,
  output logic [hts_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);

  hts_pkg::cmd_t              cmd;
  hts_pkg::status_t           status;
  logic [hts_pkg::BYTE_W-1:0] header_q, tail_q;
  logic                       reg_wr;
  logic                       reg_idx;

  // APB: no wait states; the register index sits in paddr[2].
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= hts_pkg::HEADER_RESET;
      tail_q   <= hts_pkg::TAIL_RESET;
    end else if (reg_wr) begin
      // keep only the low byte of the written word
      if (reg_idx == hts_pkg::REG_HEADER) begin
        header_q <= pwdata[hts_pkg::BYTE_W-1:0];
      end else begin
        tail_q <= pwdata[hts_pkg::BYTE_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx == hts_pkg::REG_HEADER) begin
      prdata = hts_pkg::APB_DW'(header_q);
    end else begin
      prdata = hts_pkg::APB_DW'(tail_q);
    end
  end

  hts_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_valid_i),
    .rx_stall_o    (rx_stall_o),
    .frame_valid_o (frame_valid_o),
    .frame_stall_i (frame_stall_i),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  hts_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .rx_byte_i       (rx_byte_i),
    .header_value_i  (header_q),
    .tail_value_i    (tail_q),
    .frame_byte_o    (frame_byte_o),
    .byte_position_o (byte_position_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

FILE: hdl/hts_datapath.sv
// Datapath: byte window shift line, fill count, frame position and match compare.
`include "header_tail_frame_sync_macros.svh"

module hts_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hts_pkg::cmd_t                  cmd_i,
  output hts_pkg::status_t               status_o,
  input  logic [hts_pkg::BYTE_W-1:0]     rx_byte_i,
  input  logic [hts_pkg::BYTE_W-1:0]     header_value_i,
  input  logic [hts_pkg::BYTE_W-1:0]     tail_value_i,
  output logic [hts_pkg::BYTE_W-1:0]     frame_byte_o,
  output logic [hts_pkg::POS_W-1:0]      byte_position_o,
  output logic                           last_of_frame_o
);

  // Entry 0 is the oldest byte, entry FRAME_LEN-1 the newest.
  logic [hts_pkg::BYTE_W-1:0] win_q [hts_pkg::FRAME_LEN];
  logic [hts_pkg::CNT_W-1:0]  count_q, count_d;
  logic [hts_pkg::IDX_W-1:0]  pos_q, pos_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_in || cmd_i.rotate) begin
      for (int unsigned i = 0; i < hts_pkg::FRAME_LEN - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[hts_pkg::FRAME_LEN-1] <= cmd_i.shift_in ? rx_byte_i : win_q[0];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clr_count) begin
      count_d = '0;
    end else if (cmd_i.shift_in && (count_q != hts_pkg::CNT_W'(hts_pkg::FRAME_LEN))) begin
      count_d = count_q + hts_pkg::CNT_W'(1);
    end
    pos_d = pos_q;
    if (cmd_i.clr_pos) begin
      pos_d = '0;
    end else if (cmd_i.rotate) begin
      pos_d = pos_q + hts_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  assign status_o.full     = (count_q == hts_pkg::CNT_W'(hts_pkg::FRAME_LEN));
  assign status_o.match    = (win_q[0] == header_value_i) &&
                             (win_q[hts_pkg::FRAME_LEN-1] == tail_value_i);
  assign status_o.pos_last = (pos_q == hts_pkg::IDX_W'(hts_pkg::FRAME_LEN - 1));

  assign frame_byte_o    = win_q[0];
  assign byte_position_o = hts_pkg::POS_W'(pos_q);
  assign last_of_frame_o = status_o.pos_last;

  `HTS_ASSERT_NEVER(a_count_bound, count_q > hts_pkg::CNT_W'(hts_pkg::FRAME_LEN))

endmodule

FILE: hdl/hts_ctrl.sv
// Controller: state machine that sequences accept, check and frame emission.
`include "header_tail_frame_sync_macros.svh"

module hts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_stall_o,
  output logic              frame_valid_o,
  input  logic              frame_stall_i,
  output hts_pkg::cmd_t     cmd_o,
  input  hts_pkg::status_t  status_i
);

  hts_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    rx_stall_o    = 1'b1;
    frame_valid_o = 1'b0;
    case (state_q)
      hts_pkg::ST_IDLE: begin
        rx_stall_o = 1'b0;
        if (rx_valid_i) begin
          cmd_o.shift_in = 1'b1;
          state_d        = hts_pkg::ST_CHECK;
        end
      end
      hts_pkg::ST_CHECK: begin
        if (status_i.full && status_i.match) begin
          cmd_o.clr_count = 1'b1;
          cmd_o.clr_pos   = 1'b1;
          state_d         = hts_pkg::ST_EMIT;
        end else begin
          state_d = hts_pkg::ST_IDLE;
        end
      end
      hts_pkg::ST_EMIT: begin
        frame_valid_o = 1'b1;
        if (!frame_stall_i) begin
          cmd_o.rotate = 1'b1;
          if (status_i.pos_last) begin
            state_d = hts_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = hts_pkg::ST_IDLE;
      end
    endcase
  end

  `HTS_ASSERT(a_emit_after_match, (state_q == hts_pkg::ST_CHECK) ##1 (state_q == hts_pkg::ST_EMIT) |-> $past(status_i.full && status_i.match))
  `HTS_ASSERT_NEVER(a_no_accept_while_emit, frame_valid_o && !rx_stall_o)
  `HTS_ASSERT(a_tail_ends_frame, (frame_valid_o && !frame_stall_i && status_i.pos_last) |=> (state_q == hts_pkg::ST_IDLE))

endmodule

FILE: bench/hts_frame_checker.sv
// Checker: predicts and compares the synchronised frame words of header_tail_frame_sync.
module hts_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rx_valid_i,
  input  logic                         rx_stall_i,
  input  logic [hts_pkg::BYTE_W-1:0]   rx_byte_i,
  input  logic                         frame_valid_i,
  input  logic                         frame_stall_i,
  input  logic [hts_pkg::BYTE_W-1:0]   frame_byte_i,
  input  logic [hts_pkg::POS_W-1:0]    byte_position_i,
  input  logic                         last_of_frame_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hts_pkg::ADDR_W-1:0]   paddr,
  input  logic [hts_pkg::APB_DW-1:0]   pwdata,
  input  logic                         pready,
  output int unsigned                  pending_o,
  output int unsigned                  errors_o
);

  import hts_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              last;
  } frame_word_t;

  logic [BYTE_W-1:0] window_q [FRAME_LEN];
  int unsigned       slot_next;
  int unsigned       filled;
  logic [BYTE_W-1:0] header_cfg;
  logic [BYTE_W-1:0] tail_cfg;
  frame_word_t       frame_words_due [$];

  // Slide one received byte into the window and queue a frame on header/tail match.
  function automatic void absorb_rx_byte(input logic [BYTE_W-1:0] value);
    int unsigned oldest;
    int unsigned newest;
    frame_word_t w;
    window_q[slot_next] = value;
    slot_next = (slot_next + 1) % FRAME_LEN;
    if (filled < FRAME_LEN) filled++;
    if (filled < FRAME_LEN) return;
    oldest = slot_next;
    newest = (oldest + FRAME_LEN - 1) % FRAME_LEN;
    if (window_q[oldest] != header_cfg || window_q[newest] != tail_cfg) return;
    for (int unsigned k = 0; k < FRAME_LEN; k++) begin
      w.data = window_q[(oldest + k) % FRAME_LEN];
      w.pos  = k[POS_W-1:0];
      w.last = (k == FRAME_LEN - 1);
      frame_words_due.push_back(w);
    end
    filled = 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_word_t want;
    int unsigned errs;
    errs = 0;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < FRAME_LEN; i++) window_q[i] = '0;
      slot_next  = 0;
      filled     = 0;
      header_cfg = HEADER_RESET;
      tail_cfg   = TAIL_RESET;
      frame_words_due.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_HEADER) header_cfg = pwdata[BYTE_W-1:0];
        else if (paddr[2] == REG_TAIL) tail_cfg = pwdata[BYTE_W-1:0];
      end
      if (rx_valid_i && !rx_stall_i) absorb_rx_byte(rx_byte_i);
      if (frame_valid_i && !frame_stall_i) begin
        if (frame_words_due.size() == 0) begin
          $error("frame word with none due: frame_byte %0h, byte_position %0d, last %0b",
                 frame_byte_i, byte_position_i, last_of_frame_i);
          errs++;
        end else begin
          want = frame_words_due.pop_front();
          if (frame_byte_i !== want.data) begin
            $error("frame_byte: expected %0h, got %0h", want.data, frame_byte_i);
            errs++;
          end
          if (byte_position_i !== want.pos) begin
            $error("byte_position: expected %0d, got %0d", want.pos, byte_position_i);
            errs++;
          end
          if (last_of_frame_i !== want.last) begin
            $error("last_of_frame: expected %0b, got %0b", want.last, last_of_frame_i);
            errs++;
          end
        end
      end
      errors_o  <= errors_o + errs;
      pending_o <= frame_words_due.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for header_tail_frame_sync.
module tb_top;

  import hts_pkg::*;

  // Register addresses: index in paddr[2], word aligned.
  localparam logic [ADDR_W-1:0] HEADER_ADDR = {REG_HEADER, 2'b00};
  localparam logic [ADDR_W-1:0] TAIL_ADDR   = {REG_TAIL, 2'b00};

  // A byte is compared the cycle after it is taken; allow a margin on top.
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 3 * FRAME_LEN;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_WORDS    = 73;

  // Opening run at the reset header 0x55 and tail 0xFF. The first twenty bytes
  // make a frame; the byte after it would match again with the window slid by
  // one, and must not since the fill count restarts after a frame.
  localparam logic [BYTE_W-1:0] OPENING [0:20] = '{
    8'h55, 8'h55, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'hAA, 8'h55,
    8'h12, 8'h34, 8'hFF, 8'h00, 8'hC3, 8'h3C, 8'h69, 8'h96, 8'hF0, 8'hFF,
    8'hFF
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                rx_valid_i    = 1'b0;
  logic                rx_stall_o;
  logic [BYTE_W-1:0]   rx_byte_i     = '0;
  logic                frame_valid_o;
  logic                frame_stall_i = 1'b0;
  logic [BYTE_W-1:0]   frame_byte_o;
  logic [POS_W-1:0]    byte_position_o;
  logic                last_of_frame_o;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ADDR_W-1:0]   paddr         = '0;
  logic [APB_DW-1:0]   pwdata        = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int unsigned         frame_words_pending;
  int unsigned         mismatches;

  // Stimulus bookkeeping.
  logic [BYTE_W-1:0]   cur_header    = HEADER_RESET;
  logic [BYTE_W-1:0]   cur_tail      = TAIL_RESET;
  logic                steady_sender = 1'b0;
  int unsigned         words_sent    = 0;
  int unsigned         reg_writes    = 0;
  int unsigned         settings_seen = 1;

  // Watchdog and coverage counters.
  int unsigned         quiet_cycles  = 0;
  int unsigned         frames_seen   = 0;
  int unsigned         words_out     = 0;

  // Receiver stall pattern.
  int unsigned         stall_left    = 0;
  int unsigned         open_left     = 0;

  always #6 clk_i = ~clk_i;

  header_tail_frame_sync dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (rx_valid_i),
    .rx_stall_o      (rx_stall_o),
    .rx_byte_i       (rx_byte_i),
    .frame_valid_o   (frame_valid_o),
    .frame_stall_i   (frame_stall_i),
    .frame_byte_o    (frame_byte_o),
    .byte_position_o (byte_position_o),
    .last_of_frame_o (last_of_frame_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  hts_frame_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (rx_valid_i),
    .rx_stall_i      (rx_stall_o),
    .rx_byte_i       (rx_byte_i),
    .frame_valid_i   (frame_valid_o),
    .frame_stall_i   (frame_stall_i),
    .frame_byte_i    (frame_byte_o),
    .byte_position_i (byte_position_o),
    .last_of_frame_i (last_of_frame_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .pending_o       (frame_words_pending),
    .errors_o        (mismatches)
  );

  // Receiver back-pressure: alternate open stretches and stall bursts, mostly
  // short, now and then a long stall or a long open stretch with no stalling.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      frame_stall_i <= 1'b1;
      stall_left    <= stall_left - 1;
    end else if (open_left != 0) begin
      frame_stall_i <= 1'b0;
      open_left     <= open_left - 1;
    end else begin
      frame_stall_i <= 1'b0;
      open_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90) : $urandom_range(0, 4);
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 3);
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((rx_valid_i && rx_stall_o === 1'b0) || (frame_valid_o && !frame_stall_i) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (frame_valid_o && !frame_stall_i) begin
      words_out <= words_out + 1;
      if (last_of_frame_o) frames_seen <= frames_seen + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d frame words still due",
               WATCHDOG_LIMIT, frame_words_pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sender gap: mostly none or short, a few long.
  function automatic int unsigned draw_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one word and hold it until taken, then idle for a random gap.
  task automatic send_word(input logic [BYTE_W-1:0] value);
    int unsigned gap;
    rx_valid_i <= 1'b1;
    rx_byte_i  <= value;
    @(posedge clk_i);
    while (rx_stall_o !== 1'b0) @(posedge clk_i);
    words_sent++;
    gap = steady_sender ? 0 : draw_gap();
    if (gap != 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every predicted frame word has come out, then
  // let the last compare settle so the block is surely idle.
  task automatic wait_drained();
    rx_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (frame_words_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen high.
  // Leave the bus idle after the access so a following write starts afresh.
  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] value);
    logic [APB_DW-1:0] data;
    data          = $urandom;          // junk in the upper bits, must be dropped
    data[BYTE_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  // Payload byte: mostly random, sometimes the header or tail value to tempt
  // a false match further along the window.
  function automatic logic [BYTE_W-1:0] payload_byte();
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return cur_header;
    if (roll == 1) return cur_tail;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Well-formed frame: header, random body, tail.
  task automatic send_frame();
    send_word(cur_header);
    repeat (FRAME_LEN - 2) send_word(payload_byte());
    send_word(cur_tail);
  endtask

  // Broken frame: wrong header, wrong tail, or cut short.
  task automatic send_broken_frame();
    int unsigned kind;
    logic [BYTE_W-1:0] flip;
    kind = $urandom_range(0, 2);
    flip = BYTE_W'($urandom_range(1, 255));
    if (kind == 0) send_word(cur_header ^ flip);
    else send_word(cur_header);
    if (kind == 2) begin
      repeat ($urandom_range(0, FRAME_LEN - 3)) send_word(payload_byte());
    end else begin
      repeat (FRAME_LEN - 2) send_word(payload_byte());
      send_word((kind == 1) ? (cur_tail ^ flip) : cur_tail);
    end
  endtask

  // Mixed traffic until the phase has moved its share of words.
  task automatic run_stream(input int unsigned quota);
    int unsigned start;
    int unsigned roll;
    start = words_sent;
    while (words_sent - start < quota) begin
      steady_sender = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 65) send_frame();
      else if (roll < 80) send_broken_frame();
      else repeat ($urandom_range(1, 8)) send_word(payload_byte());
      // now and then hold off until the frame channel is empty
      if ($urandom_range(0, 11) == 0) wait_drained();
    end
  endtask

  // New header and tail, written only once the block has gone idle.
  task automatic run_phase(input logic [BYTE_W-1:0] header_v, input logic [BYTE_W-1:0] tail_v);
    wait_drained();
    reg_write(HEADER_ADDR, header_v);
    reg_write(TAIL_ADDR, tail_v);
    cur_header = header_v;
    cur_tail   = tail_v;
    settings_seen++;
    run_stream(PHASE_WORDS);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: frame from an empty window, suppressed overlap, then
    // a few bytes into a window that is not yet full again.
    steady_sender = 1'b1;
    foreach (OPENING[i]) send_word(OPENING[i]);
    send_word(8'h55);
    send_word(8'hFF);
    send_word(8'h00);
    send_word(8'hFF);
    steady_sender = 1'b0;

    // Random traffic at the reset setting, then through the extremes.
    run_stream(PHASE_WORDS - 25);
    run_phase(8'h00, 8'hFF);
    run_phase(8'hFF, 8'h00);
    run_phase(8'hA5, 8'hA5);
    run_phase(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
    run_phase(HEADER_RESET, TAIL_RESET);

    // Drain, then leave room for any stray word.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d received words and %0d frames (%0d frame words),",
             words_sent, frames_seen, words_out);
    $display("over %0d header/tail settings with %0d register writes.",
             settings_seen, reg_writes);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/hts_pkg.sv
hdl/hts_datapath.sv
hdl/hts_ctrl.sv
hdl/header_tail_frame_sync.sv
bench/hts_frame_checker.sv
bench/tb_top.sv
